/* sv/usphm_pkg.sv */
// Shared constants and helpers for the uniform sphere / hemisphere mapper.
// No dependencies; used by usphm_sqrt_steps, the mapper and the testbench.
`default_nettype none

package usphm_pkg;

  // Default output fraction bits (Q1.14).
  localparam int FRAC_BITS_DEF = 14;

  // 2*pi in Q3.30 and the Taylor coefficients in Q1.30.
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0] Q30_ONE    = 31'd1073741824;
  localparam logic [30:0] HALF_Q30   = 31'd536870912;
  localparam logic [30:0] INV6       = 31'd178956971;
  localparam logic [30:0] INV24      = 31'd44739243;
  localparam logic [30:0] INV120     = 31'd8947849;
  localparam logic [30:0] INV720     = 31'd1491308;
  localparam logic [30:0] INV5040    = 31'd213044;
  localparam logic [30:0] INV40320   = 31'd26631;

  // Square root datapath width (radicand up to 2^32).
  localparam int SQW = 34;

  // Q1.30 product, truncated.
  function automatic logic [30:0] mul30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = a * b;
    return p[60:30];
  endfunction

endpackage

`default_nettype wire

/* sv/usphm_sample_if.sv */
// Input channel of the sphere mapper: sample point and reference direction.
// No dependencies.
`default_nettype none

interface usphm_sample_if;
  logic               valid;
  logic               ready;
  logic        [15:0] u_frac;
  logic        [15:0] v_frac;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (output valid, u_frac, v_frac, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, u_frac, v_frac, dir_x, dir_y, dir_z, output ready);
endinterface

`default_nettype wire

/* sv/usphm_point_if.sv */
// Output channel of the sphere mapper: one point on the unit sphere.
// No dependencies.
`default_nettype none

interface usphm_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

/* sv/usphm_sqrt_steps.sv */
// A slice of the digit-by-digit integer square root: STEPS result bits,
// starting at bit weight 4^K_HI. Depends on usphm_pkg.
`default_nettype none

module usphm_sqrt_steps #(
  parameter int K_HI  = 16,
  parameter int STEPS = 4
) (
  input  logic [usphm_pkg::SQW-1:0] n_in,
  input  logic [usphm_pkg::SQW-1:0] root_in,
  output logic [usphm_pkg::SQW-1:0] n_out,
  output logic [usphm_pkg::SQW-1:0] root_out
);

  // Try each bit, subtract when it fits.
  always_comb begin
    logic [usphm_pkg::SQW-1:0] n;
    logic [usphm_pkg::SQW-1:0] root;
    logic [usphm_pkg::SQW-1:0] b;
    logic [usphm_pkg::SQW-1:0] trial;
    n    = n_in;
    root = root_in;
    for (int i = 0; i < STEPS; i++) begin
      b     = usphm_pkg::SQW'(1) << (2 * (K_HI - i));
      trial = root + b;
      if (n >= trial) begin
        n    = n - trial;
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
    end
    n_out    = n;
    root_out = root;
  end

endmodule

`default_nettype wire

/* sv/uniform_sphere_hemisphere_mapper.sv */
// Uniform sphere sampler: maps (u, v) in Q0.16 to a unit vector in Q1.FRAC_BITS,
// optionally folded into the hemisphere around dir. Ten register stages, one
// beat accepted per cycle while the output does not stall; no stage holds more than one multiply
// in series (angle scaling, sin/cos Horner steps, radius scaling, dot product).
// Depends on usphm_pkg, usphm_sample_if, usphm_point_if, usphm_sqrt_steps.
`default_nettype none

module uniform_sphere_hemisphere_mapper #(
  parameter int FRAC_BITS = usphm_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  usphm_sample_if.sink  sample,
  usphm_point_if.source point
);

  localparam int NST = 10;
  localparam int SH  = 46 - FRAC_BITS;
  localparam int OW  = FRAC_BITS + 2;
  localparam int PW  = FRAC_BITS + 18;
  localparam int SQW = usphm_pkg::SQW;

  logic hemisphere_mode;

  logic [NST:1]   vld;
  logic [NST+1:1] ld;

  // Per-stage carried fields.
  logic signed [15:0] dx_p [1:8];
  logic signed [15:0] dy_p [1:8];
  logic signed [15:0] dz_p [1:8];
  logic [2:0]         oct_p [1:6];
  logic [16:0]        zmag_p [1:7];
  logic               zneg_p [1:7];
  logic [30:0]        t_p [1:5];
  logic [30:0]        t2_p [2:5];
  logic [SQW-1:0]     sqn_p [1:5];
  logic [SQW-1:0]     sqr_p [2:5];
  logic [30:0]        a_p [3:5];
  logic [30:0]        b_p [3:5];
  logic [30:0]        s6, c6;
  logic [16:0]        w6;
  logic [47:0]        px7, py7;
  logic               cneg7, sneg7;
  logic signed [OW-1:0] ox8, oy8, oz8, ox9, oy9, oz9;
  logic signed [PW-1:0] mx9, my9, mz9;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hemisphere_mode <= 1'b0;
    end else if (cfg_we) begin
      hemisphere_mode <= cfg_wdata;
    end
  end

  // Stall chain: a stage loads when it is empty or its successor loads.
  always_comb begin
    ld[NST+1] = point.ready;
    for (int k = NST; k >= 1; k--) begin
      ld[k] = ~vld[k] | ld[k+1];
    end
  end

  assign sample.ready = ld[1];
  assign point.valid  = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[1]) begin
        vld[1] <= sample.valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: z magnitude, radicand, octant reduction, angle scaling.
  logic [16:0] zmag_c;
  logic [33:0] zsq_c;
  logic [13:0] r_c;
  logic [46:0] tprod_c;

  always_comb begin
    if (sample.u_frac[15]) begin
      zmag_c = {sample.u_frac, 1'b0} - 17'd65536;
    end else begin
      zmag_c = 17'd65536 - {sample.u_frac, 1'b0};
    end
    zsq_c = 34'(zmag_c) * 34'(zmag_c);
    if (sample.v_frac[13]) begin
      r_c = 14'd8192 - {1'b0, sample.v_frac[12:0]};
    end else begin
      r_c = {1'b0, sample.v_frac[12:0]};
    end
    tprod_c = 47'(r_c) * 47'(usphm_pkg::TWO_PI_Q30) + 47'(1 << 15);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      dx_p[1]   <= sample.dir_x;
      dy_p[1]   <= sample.dir_y;
      dz_p[1]   <= sample.dir_z;
      oct_p[1]  <= sample.v_frac[15:13];
      zmag_p[1] <= zmag_c;
      zneg_p[1] <= ~sample.u_frac[15];
      t_p[1]    <= {1'b0, tprod_c[45:16]};
      sqn_p[1]  <= (SQW'(1) << 32) - zsq_c;
    end
  end

  // Square root slices.
  logic [SQW-1:0] sqn_c [2:6];
  logic [SQW-1:0] sqr_c [2:6];

  usphm_sqrt_steps #(.K_HI(16), .STEPS(4)) u_sq2 (
    .n_in(sqn_p[1]), .root_in('0), .n_out(sqn_c[2]), .root_out(sqr_c[2]));
  usphm_sqrt_steps #(.K_HI(12), .STEPS(4)) u_sq3 (
    .n_in(sqn_p[2]), .root_in(sqr_p[2]), .n_out(sqn_c[3]), .root_out(sqr_c[3]));
  usphm_sqrt_steps #(.K_HI(8), .STEPS(4)) u_sq4 (
    .n_in(sqn_p[3]), .root_in(sqr_p[3]), .n_out(sqn_c[4]), .root_out(sqr_c[4]));
  usphm_sqrt_steps #(.K_HI(4), .STEPS(4)) u_sq5 (
    .n_in(sqn_p[4]), .root_in(sqr_p[4]), .n_out(sqn_c[5]), .root_out(sqr_c[5]));
  usphm_sqrt_steps #(.K_HI(0), .STEPS(1)) u_sq6 (
    .n_in(sqn_p[5]), .root_in(sqr_p[5]), .n_out(sqn_c[6]), .root_out(sqr_c[6]));

  // Stages 2..6: advance sqrt and polynomial; carry fields along stages 2..8.
  always_ff @(posedge clk) begin
    for (int k = 2; k <= 8; k++) begin
      if (ld[k]) begin
        dx_p[k] <= dx_p[k-1];
        dy_p[k] <= dy_p[k-1];
        dz_p[k] <= dz_p[k-1];
      end
    end
    for (int k = 2; k <= 7; k++) begin
      if (ld[k]) begin
        zmag_p[k] <= zmag_p[k-1];
        zneg_p[k] <= zneg_p[k-1];
      end
    end
    for (int k = 2; k <= 6; k++) begin
      if (ld[k]) begin
        oct_p[k] <= oct_p[k-1];
      end
    end
    for (int k = 2; k <= 5; k++) begin
      if (ld[k]) begin
        t_p[k]   <= t_p[k-1];
        sqn_p[k] <= sqn_c[k];
        sqr_p[k] <= sqr_c[k];
      end
    end
    for (int k = 3; k <= 5; k++) begin
      if (ld[k]) begin
        t2_p[k] <= t2_p[k-1];
      end
    end
    if (ld[2]) begin
      t2_p[2] <= usphm_pkg::mul30(t_p[1], t_p[1]);
    end
    if (ld[3]) begin
      a_p[3] <= usphm_pkg::INV120 - usphm_pkg::mul30(t2_p[2], usphm_pkg::INV5040);
      b_p[3] <= usphm_pkg::INV720 - usphm_pkg::mul30(t2_p[2], usphm_pkg::INV40320);
    end
    if (ld[4]) begin
      a_p[4] <= usphm_pkg::INV6 - usphm_pkg::mul30(t2_p[3], a_p[3]);
      b_p[4] <= usphm_pkg::INV24 - usphm_pkg::mul30(t2_p[3], b_p[3]);
    end
    if (ld[5]) begin
      a_p[5] <= usphm_pkg::Q30_ONE - usphm_pkg::mul30(t2_p[4], a_p[4]);
      b_p[5] <= usphm_pkg::HALF_Q30 - usphm_pkg::mul30(t2_p[4], b_p[4]);
    end
    if (ld[6]) begin
      s6 <= usphm_pkg::mul30(t_p[5], a_p[5]);
      c6 <= usphm_pkg::Q30_ONE - usphm_pkg::mul30(t2_p[5], b_p[5]);
      w6 <= sqr_c[6][16:0];
    end
  end

  // Stage 7: octant symmetry, radius times sin/cos.
  logic        swap_c;
  logic [30:0] cmag_c, smag_c;

  always_comb begin
    swap_c = oct_p[6][0] ^ oct_p[6][1];
    cmag_c = swap_c ? s6 : c6;
    smag_c = swap_c ? c6 : s6;
  end

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      px7   <= 48'(w6) * 48'(cmag_c);
      py7   <= 48'(w6) * 48'(smag_c);
      cneg7 <= oct_p[6][2] ^ oct_p[6][1];
      sneg7 <= oct_p[6][2];
    end
  end

  // Stage 8: round half up, saturate, apply sign.
  logic [48:0] xf_c, yf_c;
  logic [47:0] zf_c;
  logic [FRAC_BITS:0] xm_c, ym_c, zm_c;

  assign xf_c = ({1'b0, px7} + (49'(1) << (SH - 1))) >> SH;
  assign yf_c = ({1'b0, py7} + (49'(1) << (SH - 1))) >> SH;

  generate
    if (FRAC_BITS < 16) begin : g_zdown
      assign zf_c = (48'(zmag_p[7]) + (48'(1) << (15 - FRAC_BITS))) >> (16 - FRAC_BITS);
    end else begin : g_zup
      assign zf_c = 48'(zmag_p[7]) << (FRAC_BITS - 16);
    end
  endgenerate

  always_comb begin
    xm_c = (xf_c > (49'(1) << FRAC_BITS)) ? (FRAC_BITS+1)'(1) << FRAC_BITS
                                          : xf_c[FRAC_BITS:0];
    ym_c = (yf_c > (49'(1) << FRAC_BITS)) ? (FRAC_BITS+1)'(1) << FRAC_BITS
                                          : yf_c[FRAC_BITS:0];
    zm_c = (zf_c > (48'(1) << FRAC_BITS)) ? (FRAC_BITS+1)'(1) << FRAC_BITS
                                          : zf_c[FRAC_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      ox8 <= cneg7     ? OW'(0) - OW'(xm_c) : OW'(xm_c);
      oy8 <= sneg7     ? OW'(0) - OW'(ym_c) : OW'(ym_c);
      oz8 <= zneg_p[7] ? OW'(0) - OW'(zm_c) : OW'(zm_c);
    end
  end

  // Stage 9: dot product terms.
  always_ff @(posedge clk) begin
    if (ld[9]) begin
      ox9 <= ox8;
      oy9 <= oy8;
      oz9 <= oz8;
      mx9 <= ox8 * dx_p[8];
      my9 <= oy8 * dy_p[8];
      mz9 <= oz8 * dz_p[8];
    end
  end

  // Stage 10: sum, fold into hemisphere, output register.
  logic signed [PW+1:0] dot_c;
  logic                 flip_c;

  always_comb begin
    dot_c  = mx9 + my9 + mz9;
    flip_c = hemisphere_mode & dot_c[PW+1];
  end

  always_ff @(posedge clk) begin
    if (ld[10]) begin
      point.out_x <= 16'(flip_c ? -ox9 : ox9);
      point.out_y <= 16'(flip_c ? -oy9 : oy9);
      point.out_z <= 16'(flip_c ? -oz9 : oz9);
    end
  end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Testbench for the uniform sphere / hemisphere mapper: drives sample beats,
// predicts each point in fixed point and checks every output beat in order.
// Depends on usphm_pkg, usphm_sample_if, usphm_point_if and the mapper RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int FB       = 14;
  localparam int LATENCY  = 10;
  localparam int WDOG_MAX = 5000;

  typedef struct packed {
    logic [15:0] u;
    logic [15:0] v;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic fold_mode = 1'b0;
  logic recv_hold = 1'b0;
  logic in_acc = 1'b0;
  int   errors = 0;
  int   idle_cycles = 0;

  sample_t sample_q[$];
  point_t  point_q[$];

  usphm_sample_if sample ();
  usphm_point_if  point ();

  uniform_sphere_hemisphere_mapper #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .sample(sample.sink), .point(point.source)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Bit-serial floor square root of a 64-bit radicand.
  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned q30_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // Round half up on the magnitude, saturate to one, then apply the sign.
  function automatic longint scale_sat(input longint unsigned mag, input int from,
                                       input bit neg);
    longint unsigned m;
    int sh;
    sh = from - FB;
    m = (mag + (64'd1 << (sh - 1))) >> sh;
    if (m > (64'd1 << FB)) m = 64'd1 << FB;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Map one sample point to its expected sphere point.
  function automatic point_t map_to_sphere(input sample_t s, input logic fold);
    longint zq, ox, oy, oz, dot;
    longint unsigned zmag, w, r, t, t2, sn, cs, smag, cmag;
    bit zneg, sneg, cneg;
    logic [2:0] oct;
    point_t p;
    zq = 2 * longint'(s.u) - 65536;
    zneg = zq < 0;
    zmag = zneg ? -zq : zq;
    w = floor_sqrt((64'd1 << 32) - zmag * zmag);
    oct = s.v[15:13];
    r = 64'(s.v[12:0]);
    if (oct[0]) r = 8192 - r;
    t = (r * longint'(usphm_pkg::TWO_PI_Q30) + (64'd1 << 15)) >> 16;
    t2 = q30_mul(t, t);
    sn = usphm_pkg::INV120 - q30_mul(t2, usphm_pkg::INV5040);
    sn = usphm_pkg::INV6 - q30_mul(t2, sn);
    sn = usphm_pkg::Q30_ONE - q30_mul(t2, sn);
    sn = q30_mul(t, sn);
    cs = usphm_pkg::INV720 - q30_mul(t2, usphm_pkg::INV40320);
    cs = usphm_pkg::INV24 - q30_mul(t2, cs);
    cs = usphm_pkg::HALF_Q30 - q30_mul(t2, cs);
    cs = usphm_pkg::Q30_ONE - q30_mul(t2, cs);
    // Octant symmetry: octants 1, 2, 5 and 6 swap sin and cos.
    smag = (oct == 1 || oct == 2 || oct == 5 || oct == 6) ? cs : sn;
    cmag = (oct == 1 || oct == 2 || oct == 5 || oct == 6) ? sn : cs;
    sneg = oct[2];
    cneg = (oct == 2 || oct == 3 || oct == 4 || oct == 5);
    ox = scale_sat(w * cmag, 46, cneg);
    oy = scale_sat(w * smag, 46, sneg);
    oz = scale_sat(zmag, 16, zneg);
    if (fold) begin
      dot = ox * longint'(s.dx) + oy * longint'(s.dy) + oz * longint'(s.dz);
      if (dot < 0) begin
        ox = -ox;
        oy = -oy;
        oz = -oz;
      end
    end
    p.x = ox[15:0];
    p.y = oy[15:0];
    p.z = oz[15:0];
    return p;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Record the input handshake at the edge where it happens.
  always @(posedge clk) begin
    in_acc <= sample.valid && sample.ready;
  end

  // Sender: present beats from the pending queue, with random gaps.
  int send_gap = 0;
  initial begin
    sample.valid = 1'b0;
    sample.u_frac = '0;
    sample.v_frac = '0;
    sample.dir_x = '0;
    sample.dir_y = '0;
    sample.dir_z = '0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (in_acc) begin
        point_q.push_back(map_to_sphere(sample_q.pop_front(), fold_mode));
        send_gap <= gap_len();
      end
      if (sample.valid && !in_acc) begin
        // hold the beat until accepted
      end else if (send_gap > 0 && !in_acc) begin
        send_gap <= send_gap - 1;
        sample.valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        sample.valid <= 1'b1;
        {sample.u_frac, sample.v_frac, sample.dir_x, sample.dir_y, sample.dir_z} <=
          sample_q[0];
      end else begin
        sample.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random; once recv_hold is raised, hold off for a long stretch.
  int recv_gap = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  initial point.ready = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      point.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      point.ready <= 1'b0;
    end else if (recv_hold && !hold_done) begin
      // Hold off so the pipeline fills and stalls its input.
      hold_done <= 1'b1;
      hold_cnt <= 60;
      point.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      point.ready <= 1'b0;
    end else begin
      point.ready <= 1'b1;
      recv_gap <= gap_len();
    end
  end

  // Monitor: compare each output beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && point.valid && point.ready) begin
      if (point_q.size() == 0) begin
        $display("%0t: unexpected beat x=%0d y=%0d z=%0d", $time,
                 point.out_x, point.out_y, point.out_z);
        errors++;
      end else begin
        point_t e;
        e = point_q.pop_front();
        if (e.x !== point.out_x || e.y !== point.out_y || e.z !== point.out_z) begin
          $display("%0t: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d", $time,
                   e.x, e.y, e.z, point.out_x, point.out_y, point.out_z);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (point.valid && point.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom());
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.u = 16'($urandom());
    s.v = 16'($urandom());
    if ($urandom_range(0, 9) == 0) s.u = 16'($urandom_range(0, 3) * 16384);
    if ($urandom_range(0, 9) == 0) s.v = 16'($urandom_range(0, 7) * 8192);
    s.dx = rand_dir();
    s.dy = rand_dir();
    s.dz = rand_dir();
    return s;
  endfunction

  task automatic wait_drained();
    while (sample_q.size() > 0 || point_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    fold_mode = m;
  endtask

  initial begin
    sample_t s;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: poles, equator, octant edges, zero and extreme directions.
    for (int ph = 0; ph < 2; ph++) begin
      write_mode(ph[0]);
      for (int k = 0; k < 12; k++) begin
        s.u = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : (k == 2) ? 16'h8000 :
              16'($urandom());
        s.v = (k < 8) ? 16'(k * 8192) : (k == 8) ? 16'hFFFF : 16'h1FFF;
        s.dx = (k == 3) ? 16'sd0 : (k[0] ? -16'sd16384 : 16'sd16384);
        s.dy = (k == 3) ? 16'sd0 : (k == 9) ? 16'sh8000 : 16'sh7FFF;
        s.dz = (k == 3) ? 16'sd0 : (k[1] ? 16'sd16384 : -16'sd16384);
        sample_q.push_back(s);
      end
      wait_drained();
    end

    // Random phases with alternating mode, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0]);
      for (int k = 0; k < 150; k++) sample_q.push_back(rand_sample());
      if (ph == 1) begin
        // Ask the receiver for its long hold-off during this phase.
        recv_hold = 1'b1;
      end
      wait_drained();
    end

    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
